[sv/urbw_pkg.sv]
// Shared types, constants and action codes for the serial-port ring buffers.
package urbw_pkg;

  localparam int RX_DEPTH_DEF = 128;
  localparam int TX_DEPTH_DEF = 16;

  localparam int BYTE_W   = 8;
  localparam int ACT_W    = 3;
  localparam int CNT_W    = 8;
  localparam int WAIT_W   = 8;
  localparam int RX_LVL_W = 8;
  localparam int TX_LVL_W = 5;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = ACT_W;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_RX_BYTE  = 3'd0,
    ACT_TX_READY = 3'd1,
    ACT_TX_PUT   = 3'd2,
    ACT_RX_GET   = 3'd3,
    ACT_ARM_RX   = 3'd4,
    ACT_ARM_TX   = 3'd5,
    ACT_FLUSH    = 3'd6
  } action_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

[sv/urbw_ctrl.sv]
// Sequencer: accepts a transfer, runs the datapath step and loads the result register.
module urbw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output urbw_pkg::cmd_t cmd
);
  import urbw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == S_LOAD))
    else $error("step not followed by result load");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise output valid");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

[sv/urbw_dp.sv]
// Datapath: ring buffer stores, pointers, counts, wait state and result register.
module urbw_dp #(
  parameter int RX_DEPTH = urbw_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urbw_pkg::TX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  urbw_pkg::cmd_t                     cmd,
  input  logic [urbw_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [urbw_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic [urbw_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import urbw_pkg::*;

  localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_FW = $clog2(RX_DEPTH + 1);
  localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int TX_FW = $clog2(TX_DEPTH + 1);

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  action_t           act_r;
  logic [BYTE_W-1:0] data_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [RX_PW-1:0]  rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_FW-1:0]  rx_fill_r, rx_fill_nxt;
  logic [TX_PW-1:0]  tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_FW-1:0]  tx_fill_r, tx_fill_nxt;
  logic [WAIT_W-1:0] rx_wait_r, rx_wait_nxt;
  logic              tx_waiting_r, tx_waiting_nxt;

  logic              rx_we, tx_we;
  logic              rx_valid_c, line_mem_c, line_fwd_c, wake_c, must_wait_c, dropped_c;
  logic              rx_valid_r, line_mem_r, line_fwd_r, wake_r, must_wait_r, dropped_r;
  logic [BYTE_W-1:0] rx_q_r, tx_q_r;

  logic [CNT_W-1:0]  want;
  logic [WAIT_W-1:0] rx_fill_ext;
  logic [CNT_W:0]    tx_room;

  logic [BYTE_W-1:0] rx_byte_o, line_byte_o;

  assign want        = (cnt_r > CNT_W'(RX_DEPTH)) ? CNT_W'(RX_DEPTH) : cnt_r;
  assign rx_fill_ext = WAIT_W'(rx_fill_r);
  assign tx_room     = (CNT_W+1)'(TX_DEPTH) - (CNT_W+1)'(tx_fill_r);

  function automatic logic [RX_PW-1:0] rx_wrap(input logic [RX_PW-1:0] p);
    return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_PW-1:0] tx_wrap(input logic [TX_PW-1:0] p);
    return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    rx_fill_nxt    = rx_fill_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    tx_fill_nxt    = tx_fill_r;
    rx_wait_nxt    = rx_wait_r;
    tx_waiting_nxt = tx_waiting_r;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    rx_valid_c     = 1'b0;
    line_mem_c     = 1'b0;
    line_fwd_c     = 1'b0;
    wake_c         = 1'b0;
    must_wait_c    = 1'b0;
    dropped_c      = 1'b0;
    if (cmd.exec) begin
      case (act_r)
        ACT_RX_BYTE: begin
          if (rx_fill_r < RX_FW'(RX_DEPTH)) begin
            rx_we       = 1'b1;
            rx_head_nxt = rx_wrap(rx_head_r);
            rx_fill_nxt = rx_fill_r + 1'b1;
          end else begin
            dropped_c = 1'b1;
          end
          if (rx_wait_r != '0) begin
            rx_wait_nxt = rx_wait_r - 1'b1;
            wake_c      = (rx_wait_r == WAIT_W'(1));
          end
        end
        ACT_TX_READY: begin
          if (tx_fill_r != '0) begin
            line_mem_c  = 1'b1;
            tx_tail_nxt = tx_wrap(tx_tail_r);
            tx_fill_nxt = tx_fill_r - 1'b1;
          end
          if (tx_fill_nxt < TX_FW'(TX_DEPTH / 2) && tx_waiting_r) begin
            tx_waiting_nxt = 1'b0;
            wake_c         = 1'b1;
          end
        end
        ACT_TX_PUT: begin
          if (tx_fill_r >= TX_FW'(TX_DEPTH)) begin
            dropped_c = 1'b1;
          end else if (tx_fill_r == '0) begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_wrap(tx_head_r);
            tx_tail_nxt = tx_wrap(tx_tail_r);
            line_fwd_c  = 1'b1;
            if (tx_waiting_r) begin
              tx_waiting_nxt = 1'b0;
              wake_c         = 1'b1;
            end
          end else begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_wrap(tx_head_r);
            tx_fill_nxt = tx_fill_r + 1'b1;
          end
        end
        ACT_RX_GET: begin
          if (rx_fill_r != '0) begin
            rx_valid_c  = 1'b1;
            rx_tail_nxt = rx_wrap(rx_tail_r);
            rx_fill_nxt = rx_fill_r - 1'b1;
          end
        end
        ACT_ARM_RX: begin
          if (rx_fill_ext < want) begin
            rx_wait_nxt = want - rx_fill_ext;
            must_wait_c = 1'b1;
          end
        end
        ACT_ARM_TX: begin
          if (tx_room < {1'b0, cnt_r} && tx_room < (CNT_W+1)'(TX_DEPTH / 2)) begin
            tx_waiting_nxt = 1'b1;
            must_wait_c    = 1'b1;
          end
        end
        ACT_FLUSH: begin
          rx_head_nxt    = '0;
          rx_tail_nxt    = '0;
          rx_fill_nxt    = '0;
          tx_head_nxt    = '0;
          tx_tail_nxt    = '0;
          tx_fill_nxt    = '0;
          rx_wait_nxt    = '0;
          tx_waiting_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      rx_fill_r    <= '0;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      tx_fill_r    <= '0;
      rx_wait_r    <= '0;
      tx_waiting_r <= 1'b0;
    end else begin
      rx_head_r    <= rx_head_nxt;
      rx_tail_r    <= rx_tail_nxt;
      rx_fill_r    <= rx_fill_nxt;
      tx_head_r    <= tx_head_nxt;
      tx_tail_r    <= tx_tail_nxt;
      tx_fill_r    <= tx_fill_nxt;
      rx_wait_r    <= rx_wait_nxt;
      tx_waiting_r <= tx_waiting_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head_r] <= data_r;
    end
    if (cmd.exec) begin
      rx_q_r <= rx_mem[rx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head_r] <= data_r;
    end
    if (cmd.exec) begin
      tx_q_r <= tx_mem[tx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action_t'(in_tuser[ACT_W-1:0]);
      data_r <= in_tdata[BYTE_W-1:0];
      cnt_r  <= in_tdata[BYTE_W+CNT_W-1:BYTE_W];
    end
    if (cmd.exec) begin
      rx_valid_r  <= rx_valid_c;
      line_mem_r  <= line_mem_c;
      line_fwd_r  <= line_fwd_c;
      wake_r      <= wake_c;
      must_wait_r <= must_wait_c;
      dropped_r   <= dropped_c;
    end
  end

  assign rx_byte_o   = rx_valid_r ? rx_q_r : '0;
  assign line_byte_o = line_mem_r ? tx_q_r : (line_fwd_r ? data_r : '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {6'b0,
                    TX_LVL_W'(tx_fill_r),
                    RX_LVL_W'(rx_fill_r),
                    dropped_r,
                    must_wait_r,
                    wake_r,
                    line_mem_r | line_fwd_r,
                    line_byte_o,
                    rx_valid_r,
                    rx_byte_o};
    end
  end

  a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill_r <= RX_FW'(RX_DEPTH))
    else $error("receive level beyond depth");

  a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_fill_r <= TX_FW'(TX_DEPTH))
    else $error("transmit level beyond depth");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_FLUSH) |=>
      (rx_fill_r == '0 && tx_fill_r == '0 && rx_wait_r == '0 && !tx_waiting_r))
    else $error("flush left state behind");

endmodule

[sv/uart_ring_buffers_with_wake.sv]
// Top level: serial-port receive/transmit ring buffers with wake-up signalling.
// Sequencer steps: accept the input transfer, run the step, load the result register; the
// load waits while the output holds an untaken result, and out_tvalid rises once it is loaded.
// A new input is accepted only after the previous result has been loaded (in_tready is high
// only in the idle state). The step reads the stores through a registered port.
// Reset (synchronous, rst_n low) empties both queues and clears waits; store contents
// are undefined until written.
module uart_ring_buffers_with_wake #(
  parameter int RX_DEPTH = urbw_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urbw_pkg::TX_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // data_in [7:0], count [15:8]
  input  logic [urbw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action [2:0]
  input  logic [urbw_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rx_byte [7:0], rx_valid [8], line_byte [16:9], line_valid [17], wake [18],
  // must_wait [19], dropped [20], rx_level [28:21], tx_level [33:29], zero [39:34]
  output logic [urbw_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import urbw_pkg::*;

  cmd_t cmd;

  urbw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  urbw_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

[bench/tb_uart_ring_buffers_with_wake.sv]
// Testbench for the serial-port ring buffers: stream stimulus, predicted results, field checks.
module tb_uart_ring_buffers_with_wake;
  import urbw_pkg::*;

  localparam int RXD = RX_DEPTH_DEF;
  localparam int TXD = TX_DEPTH_DEF;
  localparam int RX_PTR_W = $clog2(RXD);
  localparam int TX_PTR_W = $clog2(TXD);
  localparam logic [ACT_W-1:0] ACT_UNDEF = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [TX_LVL_W-1:0] tx_level;
    logic [RX_LVL_W-1:0] rx_level;
    logic                dropped;
    logic                must_wait;
    logic                wake;
    logic                line_valid;
    logic [BYTE_W-1:0]   line_byte;
    logic                rx_valid;
    logic [BYTE_W-1:0]   rx_byte;
  } buf_result_t;

  class ring_buffer_ledger;
    logic [BYTE_W-1:0]   rx_mem [RXD];
    logic [BYTE_W-1:0]   tx_mem [TXD];
    logic [RX_PTR_W-1:0] rx_wr, rx_rd;
    logic [TX_PTR_W-1:0] tx_wr, tx_rd;
    logic [RX_LVL_W-1:0] rx_fill;
    logic [TX_LVL_W-1:0] tx_fill;
    logic [WAIT_W-1:0]   rx_wait_left;
    logic                tx_waiting;
    buf_result_t         due_q [$];
    int errors, checked, wakes, drops, waits, peak_rx;

    function new();
      empty_queues();
      errors = 0;
      checked = 0;
      wakes = 0;
      drops = 0;
      waits = 0;
      peak_rx = 0;
    endfunction

    function void empty_queues();
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      rx_fill = '0;
      tx_fill = '0;
      rx_wait_left = '0;
      tx_waiting = 1'b0;
    endfunction

    function void serve_line(inout buf_result_t r);
      if (tx_fill > 0) begin
        r.line_byte = tx_mem[tx_rd];
        r.line_valid = 1'b1;
        tx_rd = (tx_rd == TXD - 1) ? '0 : tx_rd + 1'b1;
        tx_fill = tx_fill - 1'b1;
      end
      if (tx_fill < TXD / 2 && tx_waiting) begin
        tx_waiting = 1'b0;
        r.wake = 1'b1;
      end
    endfunction

    function buf_result_t step_buffers(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] d,
                                       logic [CNT_W-1:0] c);
      buf_result_t r;
      int want;
      int room;
      logic was_empty;
      r = '0;
      case (act)
        ACT_RX_BYTE: begin
          if (rx_fill < RXD) begin
            rx_mem[rx_wr] = d;
            rx_wr = (rx_wr == RXD - 1) ? '0 : rx_wr + 1'b1;
            rx_fill = rx_fill + 1'b1;
          end else begin
            r.dropped = 1'b1;
          end
          if (rx_wait_left != 0) begin
            rx_wait_left = rx_wait_left - 1'b1;
            if (rx_wait_left == 0) r.wake = 1'b1;
          end
        end
        ACT_TX_READY: serve_line(r);
        ACT_TX_PUT: begin
          if (tx_fill >= TXD) begin
            r.dropped = 1'b1;
          end else begin
            was_empty = (tx_fill == 0);
            tx_mem[tx_wr] = d;
            tx_wr = (tx_wr == TXD - 1) ? '0 : tx_wr + 1'b1;
            tx_fill = tx_fill + 1'b1;
            if (was_empty) serve_line(r);
          end
        end
        ACT_RX_GET: begin
          if (rx_fill > 0) begin
            r.rx_byte = rx_mem[rx_rd];
            r.rx_valid = 1'b1;
            rx_rd = (rx_rd == RXD - 1) ? '0 : rx_rd + 1'b1;
            rx_fill = rx_fill - 1'b1;
          end
        end
        ACT_ARM_RX: begin
          want = (c > RXD) ? RXD : int'(c);
          if (rx_fill < want) begin
            rx_wait_left = WAIT_W'(want - int'(rx_fill));
            r.must_wait = 1'b1;
          end
        end
        ACT_ARM_TX: begin
          room = TXD - int'(tx_fill);
          if (room < int'(c) && room < TXD / 2) begin
            tx_waiting = 1'b1;
            r.must_wait = 1'b1;
          end
        end
        ACT_FLUSH: empty_queues();
        default: ;
      endcase
      r.rx_level = rx_fill;
      r.tx_level = tx_fill;
      return r;
    endfunction

    function void note_transfer(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] d,
                                logic [CNT_W-1:0] c);
      due_q.push_back(step_buffers(act, d, c));
    endfunction

    function void cmp(string field, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td);
      buf_result_t got;
      buf_result_t want;
      got = td[$bits(buf_result_t)-1:0];
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, td);
        errors++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (want.wake) wakes++;
      if (want.dropped) drops++;
      if (want.must_wait) waits++;
      if (want.rx_level > peak_rx) peak_rx = want.rx_level;
      cmp("rx_byte", want.rx_byte, got.rx_byte);
      cmp("rx_valid", want.rx_valid, got.rx_valid);
      cmp("line_byte", want.line_byte, got.line_byte);
      cmp("line_valid", want.line_valid, got.line_valid);
      cmp("wake", want.wake, got.wake);
      cmp("must_wait", want.must_wait, got.must_wait);
      cmp("dropped", want.dropped, got.dropped);
      cmp("rx_level", want.rx_level, got.rx_level);
      cmp("tx_level", want.tx_level, got.tx_level);
      cmp("pad", 0, td[OUT_TDATA_W-1:$bits(buf_result_t)]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  ring_buffer_ledger ledger;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  uart_ring_buffers_with_wake dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // check each result transfer, then choose the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tdata);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb_uart_ring_buffers_with_wake: FAIL");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] d,
                           input logic [CNT_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= {c, d};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    ledger.note_transfer(act, d, c);
    if (act != ACT_UNDEF) items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (ledger.due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ACT_RX_BYTE;
    if (r < 55) return ACT_RX_GET;
    if (r < 65) return ACT_TX_PUT;
    if (r < 75) return ACT_TX_READY;
    if (r < 83) return ACT_ARM_RX;
    if (r < 90) return ACT_ARM_TX;
    if (r < 92) return ACT_FLUSH;
    if (r < 94) return ACT_UNDEF;
    return ACT_RX_BYTE;
  endfunction

  task automatic run_random(input int quota);
    int stop_at;
    int n;
    int c;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2: repeat (24) send_item(pick_action(), rand_byte(), rand_byte());
        3, 4: begin
          if ($urandom_range(1)) send_item(ACT_ARM_RX, rand_byte(), rand_byte());
          n = $urandom_range(20, 150);
          repeat (n) send_item(ACT_RX_BYTE, rand_byte(), rand_byte());
        end
        5: begin
          n = $urandom_range(10, 150);
          repeat (n) send_item(ACT_RX_GET, rand_byte(), rand_byte());
        end
        6: begin
          c = $urandom_range(1, 40);
          send_item(ACT_ARM_RX, rand_byte(), CNT_W'(c));
          n = c + $urandom_range(3);
          repeat (n) begin
            if ($urandom_range(9) == 0)
              send_item(ACT_RX_GET, rand_byte(), rand_byte());
            else
              send_item(ACT_RX_BYTE, rand_byte(), rand_byte());
          end
        end
        7: begin
          repeat (12) begin
            case ($urandom_range(2))
              0: send_item(ACT_TX_PUT, rand_byte(), rand_byte());
              1: send_item(ACT_TX_READY, rand_byte(), rand_byte());
              default: send_item(ACT_ARM_TX, rand_byte(), rand_byte());
            endcase
          end
        end
        8: begin
          send_item(ACT_FLUSH, rand_byte(), rand_byte());
          n = $urandom_range(1, 8);
          repeat (n) send_item(ACT_RX_BYTE, rand_byte(), rand_byte());
        end
        default: begin
          repeat (10) send_item(ACT_W'($urandom_range(7)), rand_byte(), rand_byte());
        end
      endcase
    end
  endtask

  initial begin
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_RX_GET, 8'h00, 8'h00);
    send_item(ACT_TX_READY, 8'hFF, 8'hFF);
    send_item(ACT_RX_BYTE, 8'h00, 8'h00);
    send_item(ACT_RX_BYTE, 8'hFF, 8'hFF);
    send_item(ACT_RX_GET, 8'h5A, 8'h00);
    send_item(ACT_RX_GET, 8'h00, 8'hFF);
    send_item(ACT_RX_GET, 8'hFF, 8'h00);
    send_item(ACT_ARM_RX, 8'h00, 8'h00);
    send_item(ACT_ARM_RX, 8'h00, 8'hFF);
    send_item(ACT_RX_BYTE, 8'hA5, 8'h00);
    send_item(ACT_ARM_RX, 8'h00, 8'd129);
    send_item(ACT_FLUSH, 8'hFF, 8'hFF);
    send_item(ACT_ARM_RX, 8'h00, 8'd2);
    send_item(ACT_RX_BYTE, 8'h3C, 8'h00);
    send_item(ACT_RX_BYTE, 8'hC3, 8'h00);
    send_item(ACT_TX_PUT, 8'hFF, 8'h00);
    send_item(ACT_TX_PUT, 8'h00, 8'hFF);
    send_item(ACT_TX_READY, 8'h00, 8'h00);
    send_item(ACT_ARM_TX, 8'h00, 8'hFF);
    send_item(ACT_ARM_TX, 8'hFF, 8'h00);
    send_item(ACT_UNDEF, 8'hFF, 8'hFF);
    send_item(ACT_RX_GET, 8'h00, 8'h00);
    send_item(ACT_FLUSH, 8'h00, 8'h00);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      run_random(160);
      if (p == 0) begin
        // hold the output so the block backs up onto its input
        hold_reqs = hold_reqs + 1;
        repeat (30) send_item(ACT_RX_BYTE, rand_byte(), rand_byte());
      end
      settle();
      run_random(170);
    end
    settle();

    if (ledger.due_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, ledger.due_q.size());
      ledger.errors++;
    end
    $display("Covered %0d items and %0d checked results over four idling mixes.",
             items_sent, ledger.checked);
    $display("Seen %0d wakes, %0d drops, %0d pending waits, peak receive level %0d.",
             ledger.wakes, ledger.drops, ledger.waits, ledger.peak_rx);
    if (ledger.errors == 0) begin
      $display("tb_uart_ring_buffers_with_wake: PASS");
    end else begin
      $display("tb_uart_ring_buffers_with_wake: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/urbw_pkg.sv
sv/urbw_ctrl.sv
sv/urbw_dp.sv
sv/uart_ring_buffers_with_wake.sv
bench/tb_uart_ring_buffers_with_wake.sv
